>>> rtl/ffpea_pkg.sv
package ffpea_pkg;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] region_start;
        logic [31:0] region_length;
        logic [19:0] page_index;
        logic [20:0] page_count;
    } req_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] alloc_index;
    } rsp_t;

    localparam logic [1:0] ACT_LOAD  = 2'd0;
    localparam logic [1:0] ACT_ALLOC = 2'd1;
    localparam logic [1:0] ACT_FREE  = 2'd2;
    localparam logic [1:0] ACT_NONE  = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_NOFIT  = 2'd1;
    localparam logic [1:0] ST_FULL   = 2'd2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_WALK_RD,
        S_WALK_CHK,
        S_LOAD2,
        S_RESP
    } state_t;

endpackage

>>> rtl/first_fit_page_extent_allocator_top.sv
// Load and free write one extent and then respond; a split load writes a second
// extent first. Allocate walks the list, visiting at most MAX_EXTENTS extents.
// Allocation walk does one memory read and one check per extent.
// Throughput: one request at a time; the next is taken once the response leaves.
// Reset: asynchronous, clears list head/tail and slot-in-use bits; extent memory
// is undefined until written.
module first_fit_page_extent_allocator_top #(
    parameter int MAX_EXTENTS  = 32,
    parameter int PAGE_BYTES   = 4096,
    parameter int HEADER_BYTES = 12
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ffpea_pkg::req_t   in_data,
    output logic              out_valid,
    input  logic              out_ready,
    output ffpea_pkg::rsp_t   out_data
);

    localparam int AW = $clog2(MAX_EXTENTS + 1);
    localparam int SW = $clog2(MAX_EXTENTS);
    localparam int PS = $clog2(PAGE_BYTES);
    localparam logic [AW-1:0] NIL = AW'(MAX_EXTENTS);

    logic [31:0]   mem_start [MAX_EXTENTS];
    logic [31:0]   mem_len   [MAX_EXTENTS];
    logic [AW-1:0] mem_next  [MAX_EXTENTS];

    logic [MAX_EXTENTS-1:0] used_reg, used_next;
    logic [AW-1:0] head_reg, head_next, tail_reg, tail_next;
    logic [AW-1:0] cur_reg, cur_next, prev_reg, prev_next;
    ffpea_pkg::state_t state_reg, state_next;
    ffpea_pkg::req_t req_reg;
    ffpea_pkg::rsp_t rsp_reg, rsp_next;
    logic [31:0] load2_start_reg, load2_start_next, load2_len_reg, load2_len_next;

    logic [31:0]   rd_start_reg, rd_len_reg;
    logic [AW-1:0] rd_next_reg;
    logic          rd_en;
    logic [SW-1:0] rd_addr;

    logic          wr_en, wr_lnk_en, wr_data_en;
    logic [SW-1:0] wr_addr, lnk_addr;
    logic [31:0]   wr_start, wr_len;
    logic [AW-1:0] wr_next, lnk_val;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_start[wr_addr] <= wr_start;
            mem_len[wr_addr]   <= wr_len;
        end
        if (wr_lnk_en)
            mem_next[lnk_addr] <= lnk_val;
        else if (wr_data_en)
            mem_next[wr_addr] <= wr_next;
        if (rd_en)
        begin
            rd_start_reg <= mem_start[rd_addr];
            rd_len_reg   <= mem_len[rd_addr];
            rd_next_reg  <= mem_next[rd_addr];
        end
    end

    // free slot search (priority encoders over slot-in-use bits)
    logic [SW-1:0] fs1, fs2;
    logic          has1, has2;
    always_comb
    begin
        fs1 = '0; fs2 = '0; has1 = 1'b0; has2 = 1'b0;
        for (int i = MAX_EXTENTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i])
            begin
                fs1 = SW'(i);
                has1 = 1'b1;
            end
        end
        for (int i = MAX_EXTENTS - 1; i >= 0; i--)
        begin
            if (!used_reg[i] && SW'(i) != fs1)
            begin
                fs2 = SW'(i);
                has2 = 1'b1;
            end
        end
    end

    logic [32:0] l_end, l_align;
    logic        l_split;
    logic [33:0] need, need_hdr;
    logic [52:0] free_len_w;
    logic [31:0] free_len;
    always_comb
    begin
        l_end   = {1'b0, in_data.region_start} + {1'b0, in_data.region_length};
        l_align = ({1'b0, in_data.region_start} + 33'(PAGE_BYTES - 1)) >> PS << PS;
        l_split = (in_data.region_start[PS-1:0] != '0) && !l_align[32] && (l_align < l_end);
        free_len_w = 53'(in_data.page_count) << PS;
        free_len = (free_len_w > 53'hFFFF_FFFF) ? 32'hFFFF_FFFF : free_len_w[31:0];
        need     = 34'({req_reg.page_count, {PS{1'b0}}});
        need_hdr = need + 34'(HEADER_BYTES);
    end

    logic [31:0] sh_start;
    assign sh_start = rd_start_reg + need[31:0];

    // the tail's link is taken as end of list
    logic [AW-1:0] walk_next;
    assign walk_next = (cur_reg == tail_reg || rd_next_reg > NIL) ? NIL : rd_next_reg;

    always_comb
    begin
        state_next = state_reg;
        used_next = used_reg;
        head_next = head_reg;
        tail_next = tail_reg;
        cur_next = cur_reg;
        prev_next = prev_reg;
        rsp_next = rsp_reg;
        load2_start_next = load2_start_reg;
        load2_len_next = load2_len_reg;
        rd_en = 1'b0;
        rd_addr = cur_reg[SW-1:0];
        wr_en = 1'b0; wr_data_en = 1'b0; wr_lnk_en = 1'b0;
        wr_addr = fs1; lnk_addr = tail_reg[SW-1:0];
        wr_start = in_data.region_start; wr_len = in_data.region_length;
        wr_next = NIL; lnk_val = NIL;
        case (state_reg)
            ffpea_pkg::S_IDLE:
            begin
                if (in_valid)
                begin
                    rsp_next = '{status: ffpea_pkg::ST_OK, alloc_index: '0};
                    state_next = ffpea_pkg::S_RESP;
                    case (in_data.action)
                        ffpea_pkg::ACT_LOAD:
                        begin
                            if (!has1 || (l_split && !has2))
                                rsp_next.status = ffpea_pkg::ST_FULL;
                            else
                            begin
                                wr_en = 1'b1;
                                if (l_split)
                                    wr_len = l_align[31:0] - in_data.region_start;
                                used_next[fs1] = 1'b1;
                                if (tail_reg != NIL && head_reg != NIL)
                                begin
                                    wr_lnk_en = 1'b1;
                                    lnk_val = AW'(fs1);
                                end
                                else
                                    head_next = AW'(fs1);
                                tail_next = AW'(fs1);
                                if (l_split)
                                begin
                                    load2_start_next = l_align[31:0];
                                    load2_len_next = l_end[31:0] - l_align[31:0];
                                    state_next = ffpea_pkg::S_LOAD2;
                                end
                            end
                        end
                        ffpea_pkg::ACT_ALLOC:
                        begin
                            cur_next = head_reg;
                            prev_next = NIL;
                            if (head_reg == NIL)
                                rsp_next.status = ffpea_pkg::ST_NOFIT;
                            else
                                state_next = ffpea_pkg::S_WALK_RD;
                        end
                        ffpea_pkg::ACT_FREE:
                        begin
                            if (!has1)
                                rsp_next.status = ffpea_pkg::ST_FULL;
                            else
                            begin
                                wr_en = 1'b1; wr_data_en = 1'b1;
                                wr_start = 32'({in_data.page_index, {PS{1'b0}}});
                                wr_len = free_len;
                                wr_next = head_reg;
                                used_next[fs1] = 1'b1;
                                head_next = AW'(fs1);
                                if (tail_reg == NIL)
                                    tail_next = AW'(fs1);
                            end
                        end
                        default: ;
                    endcase
                end
            end
            ffpea_pkg::S_LOAD2:
            begin
                wr_en = 1'b1;
                wr_start = load2_start_reg; wr_len = load2_len_reg;
                used_next[fs1] = 1'b1;
                wr_lnk_en = 1'b1;
                lnk_val = AW'(fs1);
                tail_next = AW'(fs1);
                state_next = ffpea_pkg::S_RESP;
            end
            ffpea_pkg::S_WALK_RD:
            begin
                rd_en = 1'b1;
                state_next = ffpea_pkg::S_WALK_CHK;
            end
            ffpea_pkg::S_WALK_CHK:
            begin
                if ({2'b0, rd_len_reg} >= need)
                begin
                    rsp_next.alloc_index = 20'(rd_start_reg >> PS);
                    state_next = ffpea_pkg::S_RESP;
                    wr_addr = cur_reg[SW-1:0];
                    if ({2'b0, rd_len_reg} >= need_hdr)
                    begin
                        wr_en = 1'b1;
                        wr_start = sh_start;
                        wr_len = rd_len_reg - need[31:0];
                    end
                    else
                    begin
                        if (prev_reg != NIL)
                        begin
                            wr_lnk_en = 1'b1;
                            lnk_addr = prev_reg[SW-1:0];
                            lnk_val = walk_next;
                        end
                        else
                            head_next = walk_next;
                        if (tail_reg == cur_reg)
                            tail_next = prev_reg;
                        used_next[cur_reg[SW-1:0]] = 1'b0;
                    end
                end
                else if (walk_next >= NIL)
                begin
                    rsp_next.status = ffpea_pkg::ST_NOFIT;
                    state_next = ffpea_pkg::S_RESP;
                end
                else
                begin
                    prev_next = cur_reg;
                    cur_next = walk_next;
                    state_next = ffpea_pkg::S_WALK_RD;
                end
            end
            ffpea_pkg::S_RESP:
            begin
                if (out_ready)
                    state_next = ffpea_pkg::S_IDLE;
            end
            default: state_next = ffpea_pkg::S_IDLE;
        endcase
    end

    always_comb
    begin
        in_ready  = (state_reg == ffpea_pkg::S_IDLE);
        out_valid = (state_reg == ffpea_pkg::S_RESP);
        out_data  = rsp_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ffpea_pkg::S_IDLE;
            used_reg  <= '0;
            head_reg  <= NIL;
            tail_reg  <= NIL;
        end
        else
        begin
            state_reg <= state_next;
            used_reg  <= used_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            req_reg <= in_data;
        cur_reg <= cur_next;
        prev_reg <= prev_next;
        rsp_reg <= rsp_next;
        load2_start_reg <= load2_start_next;
        load2_len_reg <= load2_len_next;
    end

endmodule

>>> dv/first_fit_page_extent_allocator_top_test.sv
module first_fit_page_extent_allocator_top_test;

    localparam int NUM_SLOTS = 32;
    localparam int PAGE_BYTES = 4096;
    localparam int HDR_BYTES = 12;
    localparam int NO_SLOT = NUM_SLOTS;
    localparam int IDLE_LIMIT = 20000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    ffpea_pkg::req_t in_data = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    ffpea_pkg::rsp_t out_data;

    first_fit_page_extent_allocator_top DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .in_data(in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data(out_data)
    );

    always #4 clk = ~clk;

    // free-list shadow
    logic [31:0] ext_start [NUM_SLOTS];
    logic [31:0] ext_len [NUM_SLOTS];
    int ext_next [NUM_SLOTS];
    bit ext_used [NUM_SLOTS];
    int head_slot;
    int tail_slot;

    ffpea_pkg::req_t pending_reqs[$];
    ffpea_pkg::rsp_t expected_rsps[$];
    int errors = 0;
    int idle_cycles = 0;
    int send_gap = 0;
    int recv_gap = 0;
    bit hold_off = 1'b0;
    bit stim_done = 1'b0;

    function automatic int count_free_slots();
        int n;
        n = 0;
        for (int i = 0; i < NUM_SLOTS; i++)
            if (!ext_used[i])
                n++;
        return n;
    endfunction

    function automatic int claim_slot(logic [31:0] s, logic [31:0] l);
        for (int i = 0; i < NUM_SLOTS; i++)
            if (!ext_used[i])
            begin
                ext_used[i] = 1'b1;
                ext_start[i] = s;
                ext_len[i] = l;
                ext_next[i] = NO_SLOT;
                return i;
            end
        return NO_SLOT;
    endfunction

    function automatic void link_at_tail(int s);
        ext_next[s] = NO_SLOT;
        if (tail_slot < NO_SLOT && head_slot < NO_SLOT)
            ext_next[tail_slot] = s;
        else
            head_slot = s;
        tail_slot = s;
    endfunction

    function automatic ffpea_pkg::rsp_t allocate_extent(ffpea_pkg::req_t r);
        ffpea_pkg::rsp_t rsp;
        logic [63:0] rs, en, al, need, ln;
        bit split, found;
        int prev, cur, nx, s;
        rsp = '0;
        rs = {32'd0, r.region_start};
        if (r.action == ffpea_pkg::ACT_LOAD)
        begin
            en = rs + {32'd0, r.region_length};
            al = (rs + PAGE_BYTES - 1) / PAGE_BYTES * PAGE_BYTES;
            split = (rs % PAGE_BYTES) != 0 && al <= 64'hFFFF_FFFF && al < en;
            if (count_free_slots() < (split ? 2 : 1))
                rsp.status = ffpea_pkg::ST_FULL;
            else if (split)
            begin
                s = claim_slot(r.region_start, 32'(al - rs));
                link_at_tail(s);
                s = claim_slot(32'(al), 32'(en - al));
                link_at_tail(s);
            end
            else
            begin
                s = claim_slot(r.region_start, r.region_length);
                link_at_tail(s);
            end
        end
        else if (r.action == ffpea_pkg::ACT_ALLOC)
        begin
            need = {43'd0, r.page_count} * PAGE_BYTES;
            prev = NO_SLOT;
            cur = head_slot;
            found = 1'b0;
            for (int k = 0; k < NUM_SLOTS && cur < NO_SLOT && !found; k++)
            begin
                ln = {32'd0, ext_len[cur]};
                if (ln >= need)
                begin
                    found = 1'b1;
                    rsp.alloc_index = 20'(ext_start[cur] / PAGE_BYTES);
                    if (ln >= need + HDR_BYTES)
                    begin
                        ext_start[cur] = 32'({32'd0, ext_start[cur]} + need);
                        ext_len[cur] = 32'(ln - need);
                    end
                    else
                    begin
                        nx = ext_next[cur];
                        if (prev < NO_SLOT)
                            ext_next[prev] = nx;
                        else
                            head_slot = nx;
                        if (tail_slot == cur)
                            tail_slot = prev;
                        ext_used[cur] = 1'b0;
                    end
                end
                else
                begin
                    prev = cur;
                    cur = ext_next[cur];
                end
            end
            if (!found)
                rsp.status = ffpea_pkg::ST_NOFIT;
        end
        else if (r.action == ffpea_pkg::ACT_FREE)
        begin
            ln = {43'd0, r.page_count} * PAGE_BYTES;
            if (ln > 64'hFFFF_FFFF)
                ln = 64'hFFFF_FFFF;
            s = claim_slot(32'({44'd0, r.page_index} * PAGE_BYTES), 32'(ln));
            if (s >= NO_SLOT)
                rsp.status = ffpea_pkg::ST_FULL;
            else
            begin
                ext_next[s] = head_slot;
                head_slot = s;
                if (tail_slot >= NO_SLOT)
                    tail_slot = s;
            end
        end
        return rsp;
    endfunction

    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (p < 50)
            return 0;
        if (p < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] rand_word();
        case ($urandom_range(0, 5))
            0: return 32'd0;
            1: return 32'hFFFF_FFFF;
            2: return $urandom_range(0, 255) * PAGE_BYTES;
            default: return $urandom();
        endcase
    endfunction

    function automatic ffpea_pkg::req_t rand_req();
        ffpea_pkg::req_t r;
        int p;
        r = '0;
        r.region_start = rand_word();
        r.region_length = ($urandom_range(0, 3) == 0) ? rand_word()
                                                         : $urandom_range(0, 64) * 1024;
        r.page_index = 20'($urandom());
        r.page_count = ($urandom_range(0, 9) == 0) ? 21'($urandom())
                                                    : 21'($urandom_range(0, 20));
        p = $urandom_range(0, 99);
        if (p < 30)
            r.action = ffpea_pkg::ACT_LOAD;
        else if (p < 70)
            r.action = ffpea_pkg::ACT_ALLOC;
        else if (p < 97)
            r.action = ffpea_pkg::ACT_FREE;
        else
            r.action = ffpea_pkg::ACT_NONE;
        return r;
    endfunction

    function automatic ffpea_pkg::req_t mk(logic [1:0] a, logic [31:0] s, logic [31:0] l,
                                           logic [19:0] pi, logic [20:0] pc);
        ffpea_pkg::req_t r;
        r.action = a;
        r.region_start = s;
        r.region_length = l;
        r.page_index = pi;
        r.page_count = pc;
        return r;
    endfunction

    initial
    begin
        head_slot = NO_SLOT;
        tail_slot = NO_SLOT;
        for (int i = 0; i < NUM_SLOTS; i++)
        begin
            ext_used[i] = 1'b0;
            ext_next[i] = NO_SLOT;
        end
        pending_reqs.push_back(mk(ffpea_pkg::ACT_ALLOC, 0, 0, 0, 1));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_FREE, 0, 0, 20'hFFFFF, 21'h100000));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_ALLOC, 0, 0, 0, 0));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_LOAD, 32'h0000_1234, 32'h0001_0000, 0, 0));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_LOAD, 32'hFFFF_F001, 32'hFFFF_FFFF, 0, 0));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_LOAD, 32'h0000_0010, 32'h0000_0100, 0, 0));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_LOAD, 32'h0010_0000, 32'd0, 0, 0));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_LOAD, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 0, 0));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_ALLOC, 0, 0, 0, 0));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_ALLOC, 0, 0, 0, 1));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_ALLOC, 0, 0, 0, 21'h1FFFFF));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_ALLOC, 0, 0, 0, 15));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_FREE, 0, 0, 20'h12345, 21'h1FFFFF));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_NONE, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                                  20'hFFFFF, 21'h1FFFFF));
        for (int i = 0; i < 34; i++)
            pending_reqs.push_back(mk(ffpea_pkg::ACT_FREE, 0, 0, 20'(i), 21'(i)));
        pending_reqs.push_back(mk(ffpea_pkg::ACT_LOAD, 32'h0000_0001, 32'h0000_2000, 0, 0));
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        for (int i = 0; i < 1150; i++)
        begin
            if (i == 400)
            begin
                while (pending_reqs.size() != 0 || expected_rsps.size() != 0)
                    @(posedge clk);
                hold_off = 1'b1;
            end
            pending_reqs.push_back(rand_req());
        end
        while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0)
            @(posedge clk);
        repeat (80) @(posedge clk);
        if (errors == 0)
            $display("first_fit_page_extent_allocator_top_test OK");
        else
            $display("first_fit_page_extent_allocator_top_test NOT OK");
        $finish;
    end

    // driver
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && in_ready)
            begin
                expected_rsps.push_back(allocate_extent(in_data));
                send_gap = pick_gap();
            end
            if (!in_valid || in_ready)
            begin
                if (send_gap == 0 && pending_reqs.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data <= pending_reqs.pop_front();
                end
                else
                begin
                    in_valid <= 1'b0;
                    if (send_gap > 0)
                        send_gap--;
                end
            end
        end
    end

    // monitor
    always @(posedge clk)
    begin
        ffpea_pkg::rsp_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                if (expected_rsps.size() == 0)
                begin
                    $error("unexpected response %p", out_data);
                    errors++;
                end
                else
                begin
                    want = expected_rsps.pop_front();
                    if (out_data.status !== want.status)
                    begin
                        $error("status exp %0d got %0d", want.status, out_data.status);
                        errors++;
                    end
                    if (out_data.alloc_index !== want.alloc_index)
                    begin
                        $error("alloc_index exp %h got %h", want.alloc_index,
                               out_data.alloc_index);
                        errors++;
                    end
                end
                recv_gap = pick_gap();
            end
            if (hold_off)
            begin
                hold_off = 1'b0;
                recv_gap = 300;
            end
            if (recv_gap > 0)
            begin
                recv_gap--;
                out_ready <= 1'b0;
            end
            else
                out_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("first_fit_page_extent_allocator_top_test NOT OK");
            $finish;
        end
    end

endmodule

>>> filelist.f
rtl/ffpea_pkg.sv
rtl/first_fit_page_extent_allocator_top.sv
dv/first_fit_page_extent_allocator_top_test.sv
